### rtl/u2a_pkg.sv
// Shared types, constants and helpers for the 16-bit to ASCII digit converter.
`timescale 1ns / 1ps
`default_nettype none

package u2a_pkg;

    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned LEN_W       = 3;
    localparam int unsigned MAX_DIGITS  = 5;
    localparam int unsigned STEP_W      = 3;
    localparam int unsigned HEX_SHIFT   = 4;
    localparam int unsigned RADIX_DEC   = 10;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam int unsigned RECIP_DEC   = 52429;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = 32;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_NUL     = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PUSH
    } t_front_state;

    // one converted number: digits least significant first
    typedef struct packed {
        logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
        logic [LEN_W-1:0]                   ndig;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_push;

    typedef struct packed {
        logic empty;
        t_rec rec;
    } t_head;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(RADIX_DEC)) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_UPPER_A + CHAR_W'(d) - CHAR_W'(RADIX_DEC);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/u2a_if.sv
// Valid/ready channel interfaces for the converter input and character output.
`timescale 1ns / 1ps
`default_nettype none

interface u2a_in_if import u2a_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               hex_mode;

    modport source (output valid, output value, output hex_mode, input ready);
    modport sink   (input valid, input value, input hex_mode, output ready);
endinterface

interface u2a_out_if import u2a_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;
    logic [LEN_W-1:0]  total_length;

    modport source (output valid, output ascii_char, output last_char,
                    output total_length, input ready);
    modport sink   (input valid, input ascii_char, input last_char,
                    input total_length, output ready);
endinterface

`default_nettype wire

### rtl/u2a_front.sv
// Front end: accepts a number and extracts its digits, one per cycle.
`timescale 1ns / 1ps
`default_nettype none

module u2a_front import u2a_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    u2a_in_if.sink      i_in,
    output t_push       o_push,
    input  wire         i_full
);

    t_front_state                       r_state, n_state;
    logic [VALUE_W-1:0]                 r_val, n_val;
    logic                               r_hex, n_hex;
    logic [STEP_W-1:0]                  r_step, n_step;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] r_digits, n_digits;
    logic [LEN_W-1:0]                   r_ndig, n_ndig;

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quo;
    logic [VALUE_W-1:0] quo_x10;
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] next_val;

    // one radix step on the working value
    always_comb begin
        prod    = PROD_W'(r_val) * PROD_W'(RECIP_DEC);
        quo     = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
        quo_x10 = VALUE_W'(quo * VALUE_W'(RADIX_DEC));
        if (r_hex) begin
            digit    = r_val[DIGIT_W-1:0];
            next_val = r_val >> HEX_SHIFT;
        end else begin
            digit    = DIGIT_W'(r_val - quo_x10);
            next_val = quo;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_hex    = r_hex;
        n_step   = r_step;
        n_digits = r_digits;
        n_ndig   = r_ndig;
        i_in.ready   = 1'b0;
        o_push.valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_val   = i_in.value;
                    n_hex   = i_in.hex_mode;
                    n_step  = '0;
                    n_ndig  = LEN_W'(1);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_digits[r_step] = digit;
                n_val            = next_val;
                n_step           = r_step + STEP_W'(1);
                if (digit != '0) begin
                    n_ndig = LEN_W'(r_step) + LEN_W'(1);
                end
                if (r_step == STEP_W'(MAX_DIGITS - 1)) begin
                    o_push.valid = 1'b1;
                    n_state      = i_full ? ST_PUSH : ST_IDLE;
                end
            end
            ST_PUSH: begin
                o_push.valid = 1'b1;
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        o_push.rec.digits = n_digits;
        o_push.rec.ndig   = n_ndig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_val    <= n_val;
        r_hex    <= n_hex;
        r_step   <= n_step;
        r_digits <= n_digits;
        r_ndig   <= n_ndig;
    end

endmodule

`default_nettype wire

### rtl/u2a_fifo.sv
// Two-entry queue of converted numbers between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module u2a_fifo import u2a_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    input  wire   i_pop,
    output t_head o_head
);

    t_rec       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    always_comb begin
        o_full       = (r_cnt == 2'd2);
        o_head.empty = (r_cnt == 2'd0);
        o_head.rec   = r_mem[r_rp];
        do_push      = i_push.valid && !o_full;
        do_pop       = i_pop && !o_head.empty;
        n_wp         = do_push ? ~r_wp : r_wp;
        n_rp         = do_pop ? ~r_rp : r_rp;
        n_cnt        = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push.rec;
        end
    end

endmodule

`default_nettype wire

### rtl/u2a_back.sv
// Back end: walks a converted number out as characters, terminator last.
`timescale 1ns / 1ps
`default_nettype none

module u2a_back import u2a_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    u2a_out_if.source   o_out
);

    logic              r_have, n_have;
    t_rec              r_rec, n_rec;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic              r_ov, n_ov;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic [LEN_W-1:0]  r_len, n_len;

    logic              load;
    logic              at_term;
    logic              pop_fire;
    logic [LEN_W-1:0]  sel;

    always_comb begin
        load     = !r_ov || o_out.ready;
        at_term  = (r_idx == r_rec.ndig);
        o_pop    = !r_have || (load && at_term);
        pop_fire = o_pop && !i_head.empty;
        sel      = r_rec.ndig - LEN_W'(1) - r_idx;

        n_have = r_have;
        n_rec  = r_rec;
        n_idx  = r_idx;
        n_ov   = r_ov;
        n_char = r_char;
        n_last = r_last;
        n_len  = r_len;

        if (load) begin
            n_ov = r_have;
            if (r_have) begin
                n_len = r_rec.ndig + LEN_W'(1);
                n_idx = r_idx + LEN_W'(1);
                if (at_term) begin
                    n_char = ASCII_NUL;
                    n_last = 1'b1;
                    n_have = 1'b0;
                end else begin
                    n_char = digit_to_ascii(r_rec.digits[sel]);
                    n_last = 1'b0;
                end
            end
        end

        // a fresh number takes over once the previous terminator is loaded
        if (pop_fire) begin
            n_have = 1'b1;
            n_rec  = i_head.rec;
            n_idx  = '0;
        end

        o_out.valid        = r_ov;
        o_out.ascii_char   = r_char;
        o_out.last_char    = r_last;
        o_out.total_length = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_have <= n_have;
            r_ov   <= n_ov;
            r_idx  <= n_idx;
        end
        r_rec  <= n_rec;
        r_char <= n_char;
        r_last <= n_last;
        r_len  <= n_len;
    end

endmodule

`default_nettype wire

### rtl/uint16_to_ascii_digits.sv
// Top level: 16-bit unsigned to ASCII decimal or upper-case hex digit string.
//
// Input channel i_in takes one transaction per number: value and hex_mode.
// Output channel o_out gives one transaction per character, most significant
// digit first without leading zeros, then a NUL with last_char set; every
// character carries total_length (digits plus terminator, 2 to 6).
// The front end does one radix step per cycle (a 16x16 reciprocal
// multiply for decimal, a nibble shift for hex) and takes no new number
// until the current one is pushed. The back end sends one character per
// cycle while o_out.ready is high, i.e. digits + 1 characters per number.
// A two-entry queue sits between the halves and the output is registered,
// so a stalled receiver holds the current character while the front end
// keeps converting until the queue fills; then i_in.ready stays low.
// Synchronous active-low reset empties the queue and drops o_out.valid;
// no other state is kept between numbers.
`timescale 1ns / 1ps
`default_nettype none

module uint16_to_ascii_digits import u2a_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    u2a_in_if.sink      i_in,
    u2a_out_if.source   o_out
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    u2a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .i_full  (full)
    );

    u2a_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    u2a_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### tb/sv/u2a_checker.sv
// Watches both channels of the digit converter, predicts each character and compares.
`timescale 1ns / 1ps

module u2a_checker import u2a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    u2a_in_if    i_in,
    u2a_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic [LEN_W-1:0]  len;
    } t_char_exp;

    t_char_exp expected_chars[$];
    int        fail_total = 0;

    // Digits come out of the radix loop least significant first; the queue
    // takes them most significant first, then the NUL terminator.
    task automatic queue_digit_string(input logic [VALUE_W-1:0] value,
                                      input logic hex_mode);
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] digit_rev[MAX_DIGITS];
        logic [DIGIT_W-1:0] d;
        logic [LEN_W-1:0]   len;
        int                 ndig;
        t_char_exp          item;
        rest = value;
        ndig = 0;
        do begin
            if (hex_mode) begin
                d    = rest[DIGIT_W-1:0];
                rest = rest >> HEX_SHIFT;
            end else begin
                d    = DIGIT_W'(rest % RADIX_DEC);
                rest = rest / RADIX_DEC;
            end
            digit_rev[ndig] = d;
            ndig++;
        end while (rest != 0);
        len = LEN_W'(ndig + 1);
        for (int k = ndig - 1; k >= 0; k--) begin
            if (digit_rev[k] < RADIX_DEC) begin
                item.code = ASCII_ZERO + CHAR_W'(digit_rev[k]);
            end else begin
                item.code = ASCII_UPPER_A + CHAR_W'(digit_rev[k] - RADIX_DEC);
            end
            item.last = 1'b0;
            item.len  = len;
            expected_chars.push_back(item);
        end
        item.code = ASCII_NUL;
        item.last = 1'b1;
        item.len  = len;
        expected_chars.push_back(item);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_char_exp want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character, expected none, actual %0h",
                             $time, i_out.ascii_char);
                    fail_total++;
                end else begin
                    want = expected_chars.pop_front();
                    compare_field("ascii_char", want.code, i_out.ascii_char);
                    compare_field("last_char", want.last, i_out.last_char);
                    compare_field("total_length", want.len, i_out.total_length);
                end
            end
            if (i_in.valid && i_in.ready) begin
                queue_digit_string(i_in.value, i_in.hex_mode);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_chars.size();
    end

endmodule

### tb/sv/tb.sv
// Testbench top: clock, reset, number stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb import u2a_pkg::*; ();

    localparam int unsigned MAX_IDLE    = 18;
    localparam int unsigned RANDOM_NUMS = 310;
    localparam int unsigned PHASE_LEN   = 40;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic sender_idle;
    logic receiver_stall;
    int   fail_count;
    int   pending_chars;
    int   cycle_count = 0;

    u2a_in_if  in_ch();
    u2a_out_if out_ch();

    uint16_to_ascii_digits dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    u2a_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Hold valid until the transaction is taken; valid only drops for a gap.
    task automatic send_number(input logic [VALUE_W-1:0] value, input logic hex_mode);
        int unsigned gap;
        gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.value    <= value;
        in_ch.hex_mode <= hex_mode;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Output back-pressure: a fresh random stall before each character while receiver_stall is set.
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = receiver_stall ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        logic [VALUE_W-1:0] edge_values[$];
        logic [VALUE_W-1:0] value;
        int unsigned        width;
        int unsigned        mode;
        edge_values = '{16'd0, 16'd65535, 16'd1, 16'd9, 16'd10, 16'd15, 16'd16, 16'd99,
                        16'd100, 16'd999, 16'd1000, 16'd9999, 16'd10000, 16'h00FF,
                        16'h0100, 16'h0FFF, 16'h1000, 16'hABCD, 16'h5555, 16'hAAAA};
        sender_idle    = 1'b1;
        receiver_stall = 1'b1;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.value    <= '0;
        in_ch.hex_mode <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero and full-scale in both radices, then the digit-count boundaries in decimal, the last three also in hex
        foreach (edge_values[n]) begin
            send_number(edge_values[n], 1'b0);
            if (n < 2 || n >= 17) begin
                send_number(edge_values[n], 1'b1);
            end
        end

        for (int unsigned n = 0; n < RANDOM_NUMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                mode           = $urandom_range(0, 3);
                sender_idle    = mode[0];
                receiver_stall = mode[1];
            end
            // random bit length so short and long strings both turn up often
            width = $urandom_range(0, VALUE_W);
            value = VALUE_W'($urandom) & VALUE_W'((32'h1 << width) - 1);
            send_number(value, 1'($urandom_range(0, 1)));
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending_chars != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_chars == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
